// ----- design/bfa_pkg.sv -----
`timescale 1ns / 1ps
package bfa_pkg;

	localparam int MAX_FRAMES = 4096;
	localparam int LIST_MAX   = 64;
	localparam int FRAME_W    = 12;
	localparam int CNT_W      = 13;
	localparam int FOUND_W    = 7;
	localparam int WORD_W     = 32;
	localparam int NWORDS     = MAX_FRAMES / WORD_W;
	localparam int WIDX_W     = 7;

	localparam logic [2:0] KIND_ALLOC_ONE = 3'd0;
	localparam logic [2:0] KIND_ALLOC_RUN = 3'd1;
	localparam logic [2:0] KIND_MARK_USED = 3'd2;
	localparam logic [2:0] KIND_MARK_FREE = 3'd3;
	localparam logic [2:0] KIND_QUERY     = 3'd4;
	localparam logic [2:0] KIND_LIST      = 3'd5;

	typedef struct packed {
		logic [2:0]         kind;
		logic [FRAME_W-1:0] base_frame;
		logic [CNT_W-1:0]   frame_total;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               frame_is_free;
		logic [FOUND_W-1:0] list_found;
		logic [CNT_W-1:0]   free_total;
		logic [CNT_W-1:0]   used_total;
		logic               last;
	} rsp_t;

endpackage

// ----- design/bfa_ram.sv -----
`timescale 1ns / 1ps
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/bitmap_frame_allocator_top.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_t   (kind, base_frame, frame_total)
// rsp       out        rsp_valid / rsp_stall   rsp_t   (frame, ..., last)
// cfg       in         cfg_we                  cfg_wdata (frame_count)
//
// the used map sits in a 128 x 32 ram; each visited word goes through read, load,
// four 8-frame steps and write back. a query reads one word; a run allocation scans
// once, then marks its words. after reset and after every frame_count write a
// clearing pass over all 128 words runs while req_stall is high. a listing waits
// on rsp_stall for each listed frame.
module bitmap_frame_allocator_top import bfa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_RD   = 7'b0000100,
		S_LD   = 7'b0001000,
		S_EX   = 7'b0010000,
		S_WB   = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   fc_q, used_q, n_q;
	logic [WIDX_W-1:0]  widx_q;
	logic [4:0]         pos_q;
	logic [WORD_W-1:0]  word_q;
	logic [2:0]         kind_q;
	logic [FRAME_W-1:0] start_q, first_q, res_frame_q;
	logic [CNT_W:0]     end_q;
	logic [CNT_W-1:0]   run_q;
	logic [FOUND_W-1:0] found_q, cap_q;
	logic               res_free_q, done_q, dirty_q, marking_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [CNT_W-1:0]   lim, freen;
	logic [WORD_W-1:0]  rdata, wdata;
	logic               ram_we;
	logic               slot_free, rsp_load;
	rsp_t               rsp_d;
	logic               accept;

	assign lim       = (fc_q > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : fc_q;
	assign freen     = lim - used_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign ram_we = (state_q == S_CLR) || (state_q == S_WB && dirty_q);
	assign wdata  = (state_q == S_CLR) ? '0 : word_q;

	bfa_ram #(.WIDTH(WORD_W), .DEPTH(NWORDS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx_q),
		.wdata (wdata),
		.raddr (widx_q),
		.rdata (rdata)
	);

	// one 8-frame step over the held word
	logic [WORD_W-1:0]  ex_w;
	logic [CNT_W-1:0]   ex_run;
	logic [FRAME_W-1:0] ex_first, ex_hit_f, ex_f;
	logic [2:0]         ex_hit_j;
	logic               ex_hit, ex_ok, ex_b;
	logic [3:0]         ex_inc, ex_dec;
	logic [4:0]         ex_bidx;
	logic               mark_mode, set_mode;
	logic [5:0]         ex_nxt;

	assign mark_mode = marking_q || kind_q == KIND_MARK_USED || kind_q == KIND_MARK_FREE;
	assign set_mode  = marking_q || kind_q != KIND_MARK_FREE;

	always_comb begin
		ex_w     = word_q;
		ex_run   = run_q;
		ex_first = first_q;
		ex_hit   = 1'b0;
		ex_hit_f = '0;
		ex_hit_j = '0;
		ex_inc   = '0;
		ex_dec   = '0;
		ex_bidx  = '0;
		ex_f     = '0;
		ex_ok    = 1'b0;
		ex_b     = 1'b0;
		for (int j = 0; j < 8; j++) begin
			ex_bidx = {pos_q[4:3], 3'(j)};
			ex_f    = {widx_q, ex_bidx};
			ex_ok   = {1'b0, ex_f} < lim;
			ex_b    = ex_w[ex_bidx];
			if (mark_mode) begin
				if (ex_ok && ex_f >= start_q && {2'b0, ex_f} < end_q) begin
					if (set_mode && !ex_b) begin
						ex_w[ex_bidx] = 1'b1;
						ex_inc        = ex_inc + 4'd1;
					end else if (!set_mode && ex_b) begin
						ex_w[ex_bidx] = 1'b0;
						ex_dec        = ex_dec + 4'd1;
					end
				end
			end else if (kind_q == KIND_ALLOC_RUN) begin
				if (!ex_hit && ex_ok && ex_f != '0) begin
					if (!ex_b) begin
						if (ex_run == '0) begin
							ex_first = ex_f;
						end
						ex_run = ex_run + CNT_W'(1);
						if (ex_run == n_q) begin
							ex_hit = 1'b1;
						end
					end else begin
						ex_run = '0;
					end
				end
			end else begin
				// single allocation and listing both look for the next free frame
				if (!ex_hit && ex_ok && ex_f != '0 && !ex_b && 3'(j) >= pos_q[2:0]) begin
					ex_hit   = 1'b1;
					ex_hit_f = ex_f;
					ex_hit_j = 3'(j);
				end
			end
		end
		if (kind_q == KIND_ALLOC_ONE && !mark_mode && ex_hit) begin
			ex_w[{pos_q[4:3], ex_hit_j}] = 1'b1;
		end
		if (kind_q == KIND_LIST && ex_hit) begin
			ex_nxt = {1'b0, pos_q[4:3], ex_hit_j} + 6'd1;
		end else begin
			ex_nxt = {1'b0, pos_q[4:3], 3'b000} + 6'd8;
		end
	end

	logic [WIDX_W:0] nb;
	logic [CNT_W-1:0] next_base;
	logic             scan_end;

	assign nb        = {1'b0, widx_q} + (WIDX_W+1)'(1);
	assign next_base = {nb, 5'b00000};
	assign scan_end  = (next_base >= lim) || (mark_mode && {1'b0, next_base} >= end_q);

	logic list_wait;
	assign list_wait = (state_q == S_EX) && kind_q == KIND_LIST && ex_hit
		&& found_q != '0 && !slot_free;

	always_comb begin
		rsp_load = 1'b0;
		rsp_d    = '0;
		rsp_d.frame      = res_frame_q;
		rsp_d.frame_is_free = res_free_q;
		rsp_d.list_found = found_q;
		rsp_d.free_total = freen;
		rsp_d.used_total = used_q;
		rsp_d.last       = 1'b1;
		if (state_q == S_EMIT && slot_free) begin
			rsp_load = 1'b1;
		end else if (state_q == S_EX && kind_q == KIND_LIST && ex_hit
				&& found_q != '0 && slot_free) begin
			// the held frame is not the final one
			rsp_load   = 1'b1;
			rsp_d.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			fc_q      <= '0;
			used_q    <= '0;
			widx_q    <= '0;
			pos_q     <= '0;
			done_q    <= 1'b0;
			dirty_q   <= 1'b0;
			marking_q <= 1'b0;
			found_q   <= '0;
			run_q     <= '0;
		end else if (cfg_we) begin
			fc_q    <= cfg_wdata;
			used_q  <= '0;
			widx_q  <= '0;
			state_q <= S_CLR;
		end else begin
			case (state_q)
				S_CLR: begin
					widx_q <= widx_q + WIDX_W'(1);
					if (widx_q == WIDX_W'(NWORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						kind_q      <= req.kind;
						start_q     <= req.base_frame;
						n_q         <= req.frame_total;
						end_q       <= {2'b00, req.base_frame} + {1'b0, req.frame_total};
						cap_q       <= (req.frame_total > CNT_W'(LIST_MAX))
							? FOUND_W'(LIST_MAX) : req.frame_total[FOUND_W-1:0];
						res_frame_q <= '0;
						res_free_q  <= 1'b0;
						found_q     <= '0;
						run_q       <= '0;
						first_q     <= '0;
						done_q      <= 1'b0;
						dirty_q     <= 1'b0;
						marking_q   <= 1'b0;
						pos_q       <= '0;
						widx_q      <= '0;
						state_q     <= S_EMIT;
						case (req.kind)
							KIND_ALLOC_ONE: begin
								if (lim != '0 && freen != '0) state_q <= S_RD;
							end
							KIND_ALLOC_RUN: begin
								if (lim != '0 && req.frame_total != '0
										&& freen >= req.frame_total) begin
									state_q <= S_RD;
								end
							end
							KIND_MARK_USED, KIND_MARK_FREE: begin
								widx_q <= req.base_frame[FRAME_W-1:5];
								if (req.frame_total != '0 && {1'b0, req.base_frame} < lim) begin
									state_q <= S_RD;
								end
							end
							KIND_QUERY: begin
								widx_q  <= req.base_frame[FRAME_W-1:5];
								state_q <= S_RD;
							end
							KIND_LIST: begin
								if (lim != '0 && req.frame_total != '0) state_q <= S_RD;
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					word_q <= rdata;
					if (kind_q == KIND_QUERY && !marking_q) begin
						res_free_q <= ({1'b0, start_q} < lim) && !rdata[start_q[4:0]];
						state_q    <= S_EMIT;
					end else begin
						state_q <= S_EX;
					end
				end
				S_EX: begin
					if (!list_wait) begin
						word_q <= ex_w;
						pos_q  <= ex_nxt[4:0];
						if (ex_nxt[5]) state_q <= S_WB;
						if (mark_mode) begin
							used_q  <= used_q + CNT_W'(ex_inc) - CNT_W'(ex_dec);
							dirty_q <= 1'b1;
						end else if (kind_q == KIND_ALLOC_RUN) begin
							run_q   <= ex_run;
							first_q <= ex_first;
							if (ex_hit) begin
								done_q  <= 1'b1;
								state_q <= S_WB;
							end
						end else if (kind_q == KIND_ALLOC_ONE) begin
							if (ex_hit) begin
								used_q      <= used_q + CNT_W'(1);
								dirty_q     <= 1'b1;
								res_frame_q <= ex_hit_f;
								done_q      <= 1'b1;
								state_q     <= S_WB;
							end
						end else if (ex_hit) begin
							res_frame_q <= ex_hit_f;
							found_q     <= found_q + FOUND_W'(1);
							if (found_q + FOUND_W'(1) == cap_q) begin
								state_q <= S_EMIT;
							end
						end
					end
				end
				S_WB: begin
					dirty_q <= 1'b0;
					pos_q   <= '0;
					if (done_q) begin
						if (kind_q == KIND_ALLOC_RUN && !marking_q) begin
							// run found: second pass marks it used
							marking_q   <= 1'b1;
							done_q      <= 1'b0;
							start_q     <= first_q;
							res_frame_q <= first_q;
							end_q       <= {2'b00, first_q} + {1'b0, n_q};
							widx_q      <= first_q[FRAME_W-1:5];
							state_q     <= S_RD;
						end else begin
							state_q <= S_EMIT;
						end
					end else if (scan_end) begin
						state_q <= S_EMIT;
					end else begin
						widx_q  <= nb[WIDX_W-1:0];
						state_q <= S_RD;
					end
				end
				S_EMIT: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	// a frame count write always restarts from an empty map
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == S_CLR && used_q == '0))
		else $error("config write did not start clearing");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (used_q <= lim))
		else $error("used count above managed frames");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && !rsp_d.last) |-> (kind_q == KIND_LIST && found_q != '0))
		else $error("non-final result outside a listing");

	assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == KIND_LIST && state_q != S_IDLE && state_q != S_CLR) |-> (found_q <= cap_q))
		else $error("listing went past its cap");

endmodule
